FILE: sv/plsc_pkg.sv
`timescale 1ns / 1ps

package plsc_pkg;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Which entry an insert or delete works on
    typedef enum logic [1:0] {
        AT_FRONT = 2'd0,
        AT_BACK  = 2'd1,
        AT_POS   = 2'd2
    } where_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [4:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] entry_value;
        logic               has_entry;
        logic               last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    ins;
        logic    del;
        logic    rot;
        where_t  where;
        logic    emit;
        status_t status;
        logic    has_entry;
        logic    last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_ins_ok;
        logic pos_del_ok;
        logic dump_last;
    } dp_status_t;

endpackage

FILE: sv/plsc_ctrl.sv
`timescale 1ns / 1ps

module plsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          operation,
    input  plsc_pkg::dp_status_t dp_st,
    output logic                busy,
    output plsc_pkg::ctrl_cmd_t cmd
);
    import plsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.where  = AT_FRONT;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    op_next    = operation;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    OP_INS_FRONT, OP_INS_BACK:
                    begin
                        cmd.where = (op_reg == OP_INS_FRONT) ? AT_FRONT : AT_BACK;
                        if (dp_st.full)
                            cmd.status = ST_FULL;
                        else
                            cmd.ins = 1'b1;
                    end
                    OP_INS_POS:
                    begin
                        cmd.where = AT_POS;
                        if (!dp_st.pos_ins_ok)
                            cmd.status = ST_INVALID;
                        else if (dp_st.full)
                            cmd.status = ST_FULL;
                        else
                            cmd.ins = 1'b1;
                    end
                    OP_DEL_FRONT, OP_DEL_BACK:
                    begin
                        cmd.where = (op_reg == OP_DEL_FRONT) ? AT_FRONT : AT_BACK;
                        if (dp_st.empty)
                            cmd.status = ST_EMPTY;
                        else
                            cmd.del = 1'b1;
                    end
                    OP_DEL_POS:
                    begin
                        cmd.where = AT_POS;
                        if (!dp_st.pos_del_ok)
                            cmd.status = ST_INVALID;
                        else
                            cmd.del = 1'b1;
                    end
                    OP_DUMP:
                    begin
                        if (dp_st.empty)
                            cmd.status = ST_EMPTY;
                        else
                        begin
                            // first entry goes out straight away
                            cmd.rot       = 1'b1;
                            cmd.has_entry = 1'b1;
                            cmd.last      = dp_st.dump_last;
                            if (!dp_st.dump_last)
                                state_next = S_DUMP;
                        end
                    end
                    default:
                        cmd.status = ST_INVALID;
                endcase
            end
            S_DUMP:
            begin
                cmd.emit      = 1'b1;
                cmd.rot       = 1'b1;
                cmd.has_entry = 1'b1;
                cmd.last      = dp_st.dump_last;
                if (dp_st.dump_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and latched operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

FILE: sv/plsc_dp.sv
`timescale 1ns / 1ps

module plsc_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  plsc_pkg::in_item_t   item,
    input  plsc_pkg::ctrl_cmd_t  cmd,
    output plsc_pkg::dp_status_t dp_st,
    output logic                 done,
    output plsc_pkg::out_item_t  result
);
    import plsc_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    logic signed [31:0] cells_reg [CAPACITY];
    logic signed [31:0] value_reg;
    logic [4:0]         pos_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      dump_cnt_reg;
    logic               done_reg;
    out_item_t          result_reg;

    logic [CW-1:0] last_idx;
    logic [XW-1:0] pos_x, count_x, pos_m1_x, count_m1_x;
    logic [IW-1:0] idx;

    // Status for the controller
    assign last_idx   = count_reg - CW'(1);
    assign pos_x      = XW'(pos_reg);
    assign count_x    = XW'(count_reg);
    assign pos_m1_x   = pos_x - XW'(1);
    assign count_m1_x = count_x - XW'(1);

    assign dp_st.empty      = (count_reg == '0);
    assign dp_st.full       = (count_reg == CW'(CAPACITY));
    assign dp_st.pos_ins_ok = (pos_x != '0) && (pos_x <= count_x + XW'(1));
    assign dp_st.pos_del_ok = (pos_x != '0) && (pos_x <= count_x);
    assign dp_st.dump_last  = (dump_cnt_reg == last_idx);

    // Target cell of an insert or delete
    always_comb
    begin
        case (cmd.where)
            AT_FRONT: idx = '0;
            AT_BACK:  idx = cmd.ins ? count_x[IW-1:0] : count_m1_x[IW-1:0];
            AT_POS:   idx = pos_m1_x[IW-1:0];
            default:  idx = '0;
        endcase
    end

    // Entry count after this step
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CW'(1);
        else if (cmd.del)
            count_next = last_idx;
    end

    // Shifting cells: insert opens a gap, delete closes one, dump rotates
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [IW-1:0] I_IDX = IW'(i);
        localparam logic [CW-1:0] I_CNT = CW'(i);
        logic signed [31:0] prev_val, next_val;

        if (i > 0)
        begin : g_prev
            assign prev_val = cells_reg[i-1];
        end
        else
        begin : g_noprev
            assign prev_val = '0;
        end

        if (i < CAPACITY - 1)
        begin : g_next
            assign next_val = cells_reg[i+1];
        end
        else
        begin : g_nonext
            assign next_val = cells_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.ins)
            begin
                if (I_IDX == idx)
                    cells_reg[i] <= value_reg;
                else if (I_IDX > idx)
                    cells_reg[i] <= prev_val;
            end
            else if (cmd.del)
            begin
                if (I_IDX >= idx)
                    cells_reg[i] <= next_val;
            end
            else if (cmd.rot)
            begin
                if (I_CNT == last_idx)
                    cells_reg[i] <= cells_reg[0];
                else if (I_CNT < last_idx)
                    cells_reg[i] <= next_val;
            end
        end
    end

    // Operand latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= item.value;
            pos_reg   <= item.position;
        end
    end

    // Count and dump position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.emit;
            if (cmd.load)
                dump_cnt_reg <= '0;
            else if (cmd.rot)
                dump_cnt_reg <= dump_cnt_reg + CW'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.status      <= cmd.status;
            result_reg.entry_count <= 5'(count_next);
            result_reg.entry_value <= cmd.has_entry ? cells_reg[0] : '0;
            result_reg.has_entry   <= cmd.has_entry;
            result_reg.last        <= cmd.last;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/positional_list_store_core.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in shifting cells.
// An item is taken when start is high and busy is low. An insert or delete
// latches the item, then, if it is allowed, shifts the cells from its target
// place onward by one place at once; the result strobes on done in the
// following cycle. A dump sends out one entry a cycle front to back, read from
// the front cell while the list rotates through it, so the list is back in
// order when the last entry goes out; dumping an empty list gives one result
// with status empty. Results are shown for one cycle only and cannot be held
// off: the receiver must take done and result on every cycle that done is high.
`timescale 1ns / 1ps

module positional_list_store_core #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  plsc_pkg::in_item_t item,
    output logic               done,
    output plsc_pkg::out_item_t result
);
    import plsc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    plsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .dp_st     (dp_st),
        .busy      (busy),
        .cmd       (cmd)
    );

    plsc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .dp_st  (dp_st),
        .done   (done),
        .result (result)
    );

endmodule

FILE: sv/plsc_checker.sv
`timescale 1ns / 1ps

module plsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input plsc_pkg::out_item_t result
);
    import plsc_pkg::*;

    // An accepted item holds the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after a transfer in");

    // Nothing comes out in the cycle after a transfer in
    a_no_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result right after a transfer in");

    // Dump entries come out back to back until the last one
    a_dump_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=> (done && result.has_entry))
        else $error("dump broken before last entry");

    // A result without an entry carries a zero value and is the last one
    a_zero_without_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_entry) |-> (result.entry_value == '0 && result.last))
        else $error("non-entry result with value or not last");

    // Dumped entries always carry status ok and a non-zero count
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.has_entry) |->
            (result.status == ST_OK && result.entry_count != '0))
        else $error("dumped entry with bad status or count");

endmodule

bind positional_list_store_core plsc_checker u_plsc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
